// ----- sv/wps_pkg.sv -----
// shared types, register codes and defaults for the ws2812 pixel serializer
`default_nettype none
package wps_pkg;

    localparam int PIXEL_BITS      = 24;
    localparam int BITS_LEFT_W     = 5;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int LED_COUNT_W     = 9;
    localparam int TIMING_MAX_W    = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int MAX_LEDS_DEF    = 256;
    localparam int TIMING_BITS_DEF = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LED_COUNT  = 3'd3;

    localparam int RST_BIT_PERIOD = 59;
    localparam int RST_ZERO_HIGH  = 17;
    localparam int RST_ONE_HIGH   = 35;
    localparam int RST_LED_COUNT  = 1;

    typedef struct packed {
        logic                  offer;
        logic [PIXEL_BITS-1:0] pixel;
    } t_tick;

    typedef struct packed {
        logic  valid;
        t_tick tick;
    } t_queue_head;

endpackage
`default_nettype wire

// ----- sv/wps_tick_queue.sv -----
// input front end: classifies ticks and holds them in a short queue
`default_nettype none
module wps_tick_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_pixel_valid,
    input  wire logic [7:0]           i_green,
    input  wire logic [7:0]           i_red,
    input  wire logic [7:0]           i_blue,
    output wps_pkg::t_queue_head      o_head,
    input  wire logic                 i_pop
);

    localparam int PTR_W = $clog2(wps_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(wps_pkg::QUEUE_DEPTH + 1);

    wps_pkg::t_tick r_mem [wps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    wps_pkg::t_tick   w_tick;

    assign w_full     = (r_count == CNT_W'(wps_pkg::QUEUE_DEPTH));
    assign o_in_stall = w_full;
    assign w_push     = i_in_valid && !w_full;
    assign w_pop      = i_pop && (r_count != '0);

    assign w_tick.offer = i_pixel_valid;
    assign w_tick.pixel = {i_green, i_red, i_blue};

    assign o_head.valid = (r_count != '0);
    assign o_head.tick  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(wps_pkg::QUEUE_DEPTH - 1)) ? '0
                          : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(wps_pkg::QUEUE_DEPTH - 1)) ? '0
                          : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(wps_pkg::QUEUE_DEPTH))
        else $error("tick queue count above depth");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_full && !w_pop) |=> w_full)
        else $error("tick queue lost an entry without a pop");

    a_pop_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("tick queue pop did not retire an entry");

endmodule
`default_nettype wire

// ----- sv/wps_bit_engine.sv -----
// back end: holding register, bit shifter, bit timer and result register
`default_nettype none
module wps_bit_engine #(
    parameter int MAX_LEDS    = wps_pkg::MAX_LEDS_DEF,
    parameter int TIMING_BITS = wps_pkg::TIMING_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire wps_pkg::t_queue_head             i_head,
    output logic                                  o_pop,
    input  wire logic                             i_cfg_valid,
    input  wire logic [wps_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [wps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_line_level,
    output logic                                  o_ready_res,
    output logic                                  o_pixel_dropped,
    output logic                                  o_frame_done
);

    localparam int TW = (TIMING_BITS < wps_pkg::TIMING_MAX_W) ? TIMING_BITS
                      : wps_pkg::TIMING_MAX_W;
    localparam int SW = $clog2(MAX_LEDS + 1);
    localparam int CW = (SW > wps_pkg::LED_COUNT_W) ? SW : wps_pkg::LED_COUNT_W;
    localparam int PB = wps_pkg::PIXEL_BITS;
    localparam int BW = wps_pkg::BITS_LEFT_W;

    logic [TW-1:0]                   r_period;
    logic [TW-1:0]                   r_zero_high;
    logic [TW-1:0]                   r_one_high;
    logic [wps_pkg::LED_COUNT_W-1:0] r_led_count;

    logic [PB-1:0] r_hold, n_hold;
    logic          r_hold_full, n_hold_full;
    logic [PB-1:0] r_shift, n_shift;
    logic [BW-1:0] r_bits, n_bits;
    logic [TW-1:0] r_cycle, n_cycle;
    logic [SW-1:0] r_sent, n_sent;
    logic          r_sending, n_sending;

    logic          r_out_valid;
    logic          r_line, r_ready, r_dropped, r_done;
    logic          n_line, n_dropped, n_done;

    logic          w_advance;
    logic [TW-1:0] w_high;
    logic [CW-1:0] w_led_ext;
    logic [CW-1:0] w_frame;
    logic [CW-1:0] w_sent_inc;

    assign w_advance = i_head.valid && (!r_out_valid || !i_out_stall);
    assign o_pop     = w_advance;

    assign w_led_ext = CW'(r_led_count);
    always_comb begin
        if (w_led_ext == '0) begin
            w_frame = CW'(1);
        end else if (w_led_ext > CW'(MAX_LEDS)) begin
            w_frame = CW'(MAX_LEDS);
        end else begin
            w_frame = w_led_ext;
        end
    end

    assign w_high     = r_shift[PB-1] ? r_one_high : r_zero_high;
    assign w_sent_inc = CW'(r_sent) + CW'(1);

    always_comb begin
        n_hold      = r_hold;
        n_hold_full = r_hold_full;
        n_shift     = r_shift;
        n_bits      = r_bits;
        n_cycle     = r_cycle;
        n_sent      = r_sent;
        n_sending   = r_sending;
        n_line      = 1'b0;
        n_dropped   = 1'b0;
        n_done      = 1'b0;

        if (r_sending) begin
            n_line = (r_cycle < w_high);
            if (r_cycle >= r_period) begin
                n_cycle = '0;
                n_shift = {r_shift[PB-2:0], 1'b0};
                n_bits  = r_bits - 1'b1;
                if (n_bits == '0) begin
                    n_sending = 1'b0;
                    if (w_sent_inc >= w_frame) begin
                        n_sent = '0;
                        n_done = 1'b1;
                    end else begin
                        n_sent = w_sent_inc[SW-1:0];
                    end
                end
            end else begin
                n_cycle = r_cycle + 1'b1;
            end
        end

        if (!n_sending && r_hold_full) begin
            n_shift     = r_hold;
            n_bits      = BW'(PB);
            n_cycle     = '0;
            n_sending   = 1'b1;
            n_hold_full = 1'b0;
        end

        if (i_head.tick.offer) begin
            if (r_hold_full) begin
                n_dropped = 1'b1;
            end else begin
                n_hold      = i_head.tick.pixel;
                n_hold_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= TW'(wps_pkg::RST_BIT_PERIOD);
            r_zero_high <= TW'(wps_pkg::RST_ZERO_HIGH);
            r_one_high  <= TW'(wps_pkg::RST_ONE_HIGH);
            r_led_count <= wps_pkg::LED_COUNT_W'(wps_pkg::RST_LED_COUNT);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wps_pkg::REG_BIT_PERIOD: r_period    <= i_cfg_data[TW-1:0];
                wps_pkg::REG_ZERO_HIGH:  r_zero_high <= i_cfg_data[TW-1:0];
                wps_pkg::REG_ONE_HIGH:   r_one_high  <= i_cfg_data[TW-1:0];
                wps_pkg::REG_LED_COUNT:
                    r_led_count <= i_cfg_data[wps_pkg::LED_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= '0;
            r_hold_full <= 1'b0;
            r_shift     <= '0;
            r_bits      <= '0;
            r_cycle     <= '0;
            r_sent      <= '0;
            r_sending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_hold      <= n_hold;
                r_hold_full <= n_hold_full;
                r_shift     <= n_shift;
                r_bits      <= n_bits;
                r_cycle     <= n_cycle;
                r_sent      <= n_sent;
                r_sending   <= n_sending;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_line    <= n_line;
            r_ready   <= !r_hold_full;
            r_dropped <= n_dropped;
            r_done    <= n_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_level    = r_line;
    assign o_ready_res     = r_ready;
    assign o_pixel_dropped = r_dropped;
    assign o_frame_done    = r_done;

    a_sending_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> (r_bits != '0))
        else $error("shifter active with no bits left");

    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (r_cycle == '0))
        else $error("bit timer running while idle");

    a_sent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent < SW'(MAX_LEDS))
        else $error("pixel count beyond frame limit");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_line)
            && $stable(r_done) && $stable(r_dropped) && $stable(r_ready)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

// ----- sv/ws2812_pixel_serializer.sv -----
// top level of the ws2812 one-wire pixel serializer
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_pixel_valid i_green i_red i_blue
//  out      output     o_out_valid / i_out_stall o_line_level o_ready_res
//                                                o_pixel_dropped o_frame_done
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
//  one tick transaction in, one result transaction out, one per cycle unless stalled
//  an accepted tick is popped when unstalled; its result is registered as it leaves
//  the single result register sets the latency, no clearing pass after reset
//  synchronous active-low reset empties the queue and restores register defaults
//  a stall on the output backs up the queue, which then stalls the input
`default_nettype none
module ws2812_pixel_serializer #(
    parameter int MAX_LEDS    = wps_pkg::MAX_LEDS_DEF,
    parameter int TIMING_BITS = wps_pkg::TIMING_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_pixel_valid,
    input  wire logic [7:0]                       i_green,
    input  wire logic [7:0]                       i_red,
    input  wire logic [7:0]                       i_blue,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_line_level,
    output logic                                  o_ready_res,
    output logic                                  o_pixel_dropped,
    output logic                                  o_frame_done,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [wps_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [wps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    wps_pkg::t_queue_head w_head;
    logic                 w_pop;

    assign o_cfg_ready = 1'b1;

    wps_tick_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_valid (i_pixel_valid),
        .i_green       (i_green),
        .i_red         (i_red),
        .i_blue        (i_blue),
        .o_head        (w_head),
        .i_pop         (w_pop)
    );

    wps_bit_engine #(
        .MAX_LEDS    (MAX_LEDS),
        .TIMING_BITS (TIMING_BITS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line_level    (o_line_level),
        .o_ready_res     (o_ready_res),
        .o_pixel_dropped (o_pixel_dropped),
        .o_frame_done    (o_frame_done)
    );

endmodule
`default_nettype wire

// ----- tb/ws2812_line_checker.sv -----
// scoreboard for the ws2812 pixel serializer: predicts each result transaction and compares it
`timescale 1ns / 1ps
module ws2812_line_checker
    import wps_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_stall,
    input  wire logic                   i_pixel_valid,
    input  wire logic [7:0]             i_green,
    input  wire logic [7:0]             i_red,
    input  wire logic [7:0]             i_blue,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_stall,
    input  wire logic                   i_line_level,
    input  wire logic                   i_ready_res,
    input  wire logic                   i_pixel_dropped,
    input  wire logic                   i_frame_done,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_frames
);

    localparam int REPORT_LIMIT = 200;

    typedef struct packed {
        logic line_level;
        logic ready_res;
        logic pixel_dropped;
        logic frame_done;
    } t_line_result;

    logic [TIMING_MAX_W-1:0] period_cfg;
    logic [TIMING_MAX_W-1:0] zero_high_cfg;
    logic [TIMING_MAX_W-1:0] one_high_cfg;
    logic [LED_COUNT_W-1:0]  led_cfg;

    logic [PIXEL_BITS-1:0]   hold_pix;
    logic                    hold_full;
    logic [PIXEL_BITS-1:0]   shift_pix;
    logic [BITS_LEFT_W-1:0]  bits_left;
    logic [TIMING_MAX_W-1:0] cyc_in_bit;
    logic [LED_COUNT_W-1:0]  sent_cnt;
    logic                    sending;

    t_line_result            line_expect_q[$];

    function automatic int frame_len();
        if (led_cfg == 0) return 1;
        if (led_cfg > MAX_LEDS_DEF) return MAX_LEDS_DEF;
        return int'(led_cfg);
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_BIT_PERIOD: period_cfg    = data[TIMING_MAX_W-1:0];
            REG_ZERO_HIGH:  zero_high_cfg = data[TIMING_MAX_W-1:0];
            REG_ONE_HIGH:   one_high_cfg  = data[TIMING_MAX_W-1:0];
            REG_LED_COUNT:  led_cfg       = data[LED_COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // one tick of the serializer: bit timer, shifter reload, then holder
    task automatic advance_line_tick(input logic offer, input logic [PIXEL_BITS-1:0] pix,
                                     output t_line_result res);
        logic                    was_full;
        logic [TIMING_MAX_W-1:0] high_len;
        was_full = hold_full;
        res = '0;
        if (sending) begin
            high_len = shift_pix[PIXEL_BITS-1] ? one_high_cfg : zero_high_cfg;
            res.line_level = (cyc_in_bit < high_len);
            if (cyc_in_bit >= period_cfg) begin
                cyc_in_bit = '0;
                shift_pix = shift_pix << 1;
                bits_left = bits_left - 1'b1;
                if (bits_left == 0) begin
                    sending = 1'b0;
                    sent_cnt = sent_cnt + 1'b1;
                    if (int'(sent_cnt) >= frame_len()) begin
                        sent_cnt = '0;
                        res.frame_done = 1'b1;
                    end
                end
            end else begin
                cyc_in_bit = cyc_in_bit + 1'b1;
            end
        end
        if (!sending && hold_full) begin
            shift_pix = hold_pix;
            bits_left = BITS_LEFT_W'(PIXEL_BITS);
            cyc_in_bit = '0;
            sending = 1'b1;
            hold_full = 1'b0;
        end
        if (offer) begin
            if (was_full) begin
                res.pixel_dropped = 1'b1;
            end else begin
                hold_pix = pix;
                hold_full = 1'b1;
            end
        end
        res.ready_res = !was_full;
    endtask

    task automatic check_field(input string field, input logic want, input logic got);
        if (want !== got) begin
            o_errors++;
            if (o_errors <= REPORT_LIMIT) begin
                $display("%0t: %s expected %0b actual %0b", $time, field, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_line_result want;
        t_line_result got;
        if (!i_rst_n) begin
            period_cfg    = TIMING_MAX_W'(RST_BIT_PERIOD);
            zero_high_cfg = TIMING_MAX_W'(RST_ZERO_HIGH);
            one_high_cfg  = TIMING_MAX_W'(RST_ONE_HIGH);
            led_cfg       = LED_COUNT_W'(RST_LED_COUNT);
            hold_pix      = '0;
            hold_full     = 1'b0;
            shift_pix     = '0;
            bits_left     = '0;
            cyc_in_bit    = '0;
            sent_cnt      = '0;
            sending       = 1'b0;
            line_expect_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
            end
            if (i_out_valid && !i_out_stall) begin
                got.line_level    = i_line_level;
                got.ready_res     = i_ready_res;
                got.pixel_dropped = i_pixel_dropped;
                got.frame_done    = i_frame_done;
                if (line_expect_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= REPORT_LIMIT) begin
                        $display("%0t: result transaction expected none actual %b", $time, got);
                    end
                end else begin
                    want = line_expect_q.pop_front();
                    check_field("line_level", want.line_level, got.line_level);
                    check_field("ready_res", want.ready_res, got.ready_res);
                    check_field("pixel_dropped", want.pixel_dropped, got.pixel_dropped);
                    check_field("frame_done", want.frame_done, got.frame_done);
                    o_checked++;
                    if (want.frame_done) o_frames++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_line_tick(i_pixel_valid, {i_green, i_red, i_blue}, want);
                line_expect_q.push_back(want);
            end
        end
        o_pending = line_expect_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
// testbench top for the ws2812 pixel serializer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
    import wps_pkg::*;

    localparam int STUCK_LIMIT  = 2000;
    localparam int RANDOM_TICKS = 200;
    localparam int SAT_TICKS    = 60;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_reg_write;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   pixel_valid = 1'b0;
    logic [7:0]             green       = '0;
    logic [7:0]             red         = '0;
    logic [7:0]             blue        = '0;
    logic                   out_stall   = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    wire logic in_stall;
    wire logic out_valid;
    wire logic line_level;
    wire logic ready_res;
    wire logic pixel_dropped;
    wire logic frame_done;
    wire logic cfg_ready;

    int errors;
    int pending;
    int checked;
    int frames;

    t_reg_write reg_writes[$];
    int         ticks_sent      = 0;
    int         pixels_offered  = 0;
    int         reg_writes_done = 0;
    int         stuck_cycles    = 0;
    int         cur_period      = RST_BIT_PERIOD;
    int         random_end;
    logic       steady          = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ws2812_pixel_serializer u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_pixel_valid  (pixel_valid),
        .i_green        (green),
        .i_red          (red),
        .i_blue         (blue),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_line_level   (line_level),
        .o_ready_res    (ready_res),
        .o_pixel_dropped(pixel_dropped),
        .o_frame_done   (frame_done),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    ws2812_line_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_pixel_valid  (pixel_valid),
        .i_green        (green),
        .i_red          (red),
        .i_blue         (blue),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_line_level   (line_level),
        .i_ready_res    (ready_res),
        .i_pixel_dropped(pixel_dropped),
        .i_frame_done   (frame_done),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_frames       (frames)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_high(input int period);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(1, period + 2));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_led_data();
        logic [LED_COUNT_W-1:0] leds;
        case ($urandom_range(0, 9))
            0: leds = '0;
            1: leds = LED_COUNT_W'(MAX_LEDS_DEF);
            2: leds = '1;
            default: leds = LED_COUNT_W'($urandom_range(1, 4));
        endcase
        return {7'($urandom), leds};
    endfunction

    // output side stall: mostly short bursts, some long, with quiet stretches
    initial begin
        int run;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(0, 6);
            repeat (run) @(negedge clk) out_stall <= 1'b0;
            run = pick_gap();
            repeat (run) @(negedge clk) out_stall <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("no transaction for %0d cycles", STUCK_LIMIT);
            $display("testbench: errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_tick(input logic offer, input logic [PIXEL_BITS-1:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid           <= 1'b1;
        pixel_valid        <= offer;
        {green, red, blue} <= pix;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        ticks_sent++;
        if (offer) pixels_offered++;
    endtask

    task automatic idle_ticks(input int count);
        repeat (count) send_tick(1'b0, PIXEL_BITS'($urandom));
    endtask

    task automatic queue_write(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        reg_writes.push_back('{index: idx, data: data});
    endtask

    // drains the block, then streams the queued register writes
    task automatic apply_config();
        t_reg_write w;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.data;
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
            reg_writes_done++;
            if (w.index == REG_BIT_PERIOD) cur_period = int'(w.data);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic choose_config();
        int period;
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) period = 0;
        else if (roll < 8) period = $urandom_range(1, 3);
        else period = $urandom_range(4, 7);
        queue_write(REG_BIT_PERIOD, CFG_DATA_W'(period));
        if ($urandom_range(0, 3) != 0) queue_write(REG_ZERO_HIGH, pick_high(period));
        if ($urandom_range(0, 3) != 0) queue_write(REG_ONE_HIGH, pick_high(period));
        if ($urandom_range(0, 2) != 0) queue_write(REG_LED_COUNT, pick_led_data());
        if ($urandom_range(0, 15) == 0) queue_write(REG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    // one pixel, then idle ticks around its length on the line
    task automatic send_pixel_spaced();
        int span;
        int roll;
        span = (cur_period + 1) * PIXEL_BITS;
        roll = $urandom_range(0, 9);
        send_tick(1'b1, PIXEL_BITS'($urandom));
        if (roll == 0) idle_ticks(span + $urandom_range(1, span));
        else if (roll < 3) idle_ticks(span - 1 - $urandom_range(1, 3));
        else idle_ticks(span - 1 + $urandom_range(0, 2));
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // default timing: holder fills, next offer dropped, refilled, dropped again
        send_tick(1'b1, 24'hFFFFFF);
        send_tick(1'b1, 24'h000000);
        send_tick(1'b1, 24'h5AC33C);
        send_tick(1'b1, 24'hFFFFFF);
        idle_ticks(2);

        // longest bit period mid pixel, one-bit high time equal to the bit period
        queue_write(REG_BIT_PERIOD, 16'hFFFF);
        queue_write(REG_ZERO_HIGH, 16'h0000);
        queue_write(REG_ONE_HIGH, 16'hFFFF);
        queue_write(REG_LED_COUNT, 16'h0000);
        queue_write(REG_UNUSED, 16'hFFFF);
        apply_config();
        idle_ticks(4);

        // one tick per bit, zero-length zero bits, led count of zero
        queue_write(REG_BIT_PERIOD, 16'h0000);
        queue_write(REG_ONE_HIGH, 16'h0001);
        apply_config();
        idle_ticks(60);

        // three pixel frame, holder empty between pixels
        queue_write(REG_BIT_PERIOD, 16'h0001);
        queue_write(REG_ZERO_HIGH, 16'h0002);
        queue_write(REG_ONE_HIGH, 16'h0000);
        queue_write(REG_LED_COUNT, 16'h0003);
        apply_config();
        send_tick(1'b1, 24'h000000);
        idle_ticks(70);
        send_tick(1'b1, 24'hFFFFFF);
        idle_ticks(10);
        send_tick(1'b1, 24'h817E01);
        idle_ticks(60);

        // led count above the maximum, with a pixel offered on most ticks
        queue_write(REG_BIT_PERIOD, 16'h0000);
        queue_write(REG_ZERO_HIGH, 16'h0000);
        queue_write(REG_ONE_HIGH, 16'h0001);
        queue_write(REG_LED_COUNT, 16'hFFFF);
        apply_config();
        repeat (SAT_TICKS) send_tick($urandom_range(0, 3) != 0, PIXEL_BITS'($urandom));

        random_end = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < random_end) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
                queue_write(REG_BIT_PERIOD, CFG_DATA_W'($urandom_range(8, 65535)));
                apply_config();
                send_tick(1'b1, PIXEL_BITS'($urandom));
                idle_ticks($urandom_range(2, 12));
            end
            choose_config();
            apply_config();
            repeat ($urandom_range(2, 8)) begin
                if (ticks_sent < random_end) begin
                    if ($urandom_range(0, 5) == 0) begin
                        repeat ($urandom_range(1, 30)) begin
                            send_tick($urandom_range(0, 2) == 0, PIXEL_BITS'($urandom));
                        end
                    end else begin
                        send_pixel_spaced();
                    end
                end
            end
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);

        $display("%0d ticks driven, %0d with a pixel offered, %0d register writes",
                 ticks_sent, pixels_offered, reg_writes_done);
        $display("%0d result transactions compared, %0d frame ends among them", checked, frames);
        if (errors == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
